@@ src/mvp_pkg.sv @@
// shared types, codes and constants for the movevars message stream parser
`default_nettype none
package mvp_pkg;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_payload;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  record_kind;
      logic [4:0]  field_index;
      logic [31:0] field_value;
      logic [7:0]  extra_byte;
      logic [15:0] msg_offset;
      logic [4:0]  error_code;
      logic        last;
   } rsp_payload_type;

   // parse phase
   typedef enum logic [3:0] {
      PH_IDLE, PH_NUM, PH_FOOT, PH_SKY, PH_CTRL, PH_C32, PH_C5, PH_C39, PH_C9, PH_SKIP
   } phase_type;

   // record kinds
   localparam logic [3:0] KIND_NUMERIC  = 4'd0;
   localparam logic [3:0] KIND_FOOT     = 4'd1;
   localparam logic [3:0] KIND_SKY_CHAR = 4'd2;
   localparam logic [3:0] KIND_SKY_END  = 4'd3;
   localparam logic [3:0] KIND_OP32     = 4'd4;
   localparam logic [3:0] KIND_OP5      = 4'd5;
   localparam logic [3:0] KIND_OP39_HD  = 4'd6;
   localparam logic [3:0] KIND_OP39_CH  = 4'd7;
   localparam logic [3:0] KIND_OP9_CHAR = 4'd8;
   localparam logic [3:0] KIND_OP9_END  = 4'd9;
   localparam logic [3:0] KIND_BOUNDARY = 4'd10;
   localparam logic [3:0] KIND_ERROR    = 4'd11;

   // error codes
   localparam logic [4:0] ERR_OPCODE     = 5'd1;
   localparam logic [4:0] ERR_TRUNC_NUM  = 5'd2;
   localparam logic [4:0] ERR_NONFINITE  = 5'd3;
   localparam logic [4:0] ERR_MAGNITUDE  = 5'd4;
   localparam logic [4:0] ERR_TRUNC_FOOT = 5'd5;
   localparam logic [4:0] ERR_BAD_FOOT   = 5'd6;
   localparam logic [4:0] ERR_SKY_LONG   = 5'd7;
   localparam logic [4:0] ERR_SKY_UNTERM = 5'd8;
   localparam logic [4:0] ERR_NO_BOUND   = 5'd9;
   localparam logic [4:0] ERR_BAD_BOUND  = 5'd10;
   localparam logic [4:0] ERR_DUP_44     = 5'd11;
   localparam logic [4:0] ERR_CTRL_LIMIT = 5'd12;
   localparam logic [4:0] ERR_TRUNC_CTRL = 5'd13;
   localparam logic [4:0] ERR_BAD_NAME   = 5'd14;
   localparam logic [4:0] ERR_OP9_LONG   = 5'd15;
   localparam logic [4:0] ERR_OP9_UNTERM = 5'd16;
   localparam logic [4:0] ERR_UNSUPPORTED = 5'd17;

   // opcodes
   localparam logic [7:0] OP_MOVEVARS = 8'd44;
   localparam logic [7:0] OP_BOUNDARY = 8'd13;
   localparam logic [7:0] OP_C32      = 8'd32;
   localparam logic [7:0] OP_C5       = 8'd5;
   localparam logic [7:0] OP_C39      = 8'd39;
   localparam logic [7:0] OP_C9       = 8'd9;

   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7e;
   localparam logic [4:0] LAST_FIRST_BLOCK = 5'd15;
   localparam logic [4:0] LAST_NUMERIC     = 5'd23;
   localparam logic [4:0] OP39_LAST_POS    = 5'd17;

   // config register indexes
   localparam logic [1:0] REG_SKY_LIMIT  = 2'd0;
   localparam logic [1:0] REG_STR_LIMIT  = 2'd1;
   localparam logic [1:0] REG_CTRL_LIMIT = 2'd2;
   localparam logic [1:0] REG_MAG_LIMIT  = 2'd3;

   // up to two records for one byte
   typedef struct packed {
      logic            two;
      rsp_payload_type rec0;
      rsp_payload_type rec1;
   } rec_pair_type;

   // queue status between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage
`default_nettype wire

@@ src/mvp_front.sv @@
// front end: byte parser state machine producing up to two records per byte
`default_nettype none
module mvp_front #(
   parameter int MAX_STRING_LEN = 255,
   parameter int MAX_CONTROLS   = 255,
   parameter int OFFSET_BITS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire mvp_pkg::req_payload_type in_item,
   input  wire logic [7:0]               sky_limit,
   input  wire logic [7:0]               str_limit,
   input  wire logic [7:0]               ctrl_limit,
   input  wire logic [30:0]              mag_limit,
   output logic                          push,
   output mvp_pkg::rec_pair_type         push_pair,
   input  wire mvp_pkg::q_status_type    q_status
);
   import mvp_pkg::*;

   localparam logic [7:0] STR_CAP  = 8'(MAX_STRING_LEN);
   localparam logic [7:0] CTRL_CAP = 8'(MAX_CONTROLS);

   phase_type              phase_ff, phase_in;
   logic [4:0]             bif_ff, bif_in;
   logic [4:0]             nidx_ff, nidx_in;
   logic [31:0]            word_ff, word_in;
   logic [7:0]             slen_ff, slen_in;
   logic [7:0]             ccount_ff, ccount_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic                   nterm_ff, nterm_in;
   logic [7:0]             saved_ff, saved_in;

   logic                   accept;
   logic [7:0]             b;
   logic                   fin;
   logic [OFFSET_BITS-1:0] cur, nxt, start, name_start;
   logic [31:0]            w;
   logic [7:0]             sky_lim, str_lim, ctl_lim;
   logic [4:0]             pos;
   int                     n;
   rsp_payload_type        r0, r1;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign b        = in_item.payload_byte;
   assign fin      = in_item.end_of_payload;
   assign cur      = off_ff;
   assign nxt      = off_ff + 1'b1;
   assign sky_lim  = (sky_limit < STR_CAP) ? sky_limit : STR_CAP;
   assign str_lim  = (str_limit < STR_CAP) ? str_limit : STR_CAP;
   assign ctl_lim  = (ctrl_limit < CTRL_CAP) ? ctrl_limit : CTRL_CAP;
   assign w        = {b, word_ff[23:0]};
   assign pos      = (bif_ff > OP39_LAST_POS) ? OP39_LAST_POS : bif_ff;

   function automatic rsp_payload_type mk(input logic [3:0] k, input logic [4:0] idx,
         input logic [31:0] v, input logic [7:0] x, input logic [OFFSET_BITS-1:0] o,
         input logic [4:0] e);
      rsp_payload_type r;
      r.record_kind = k;
      r.field_index = idx;
      r.field_value = v;
      r.extra_byte  = x;
      r.msg_offset  = 16'(o);
      r.error_code  = e;
      r.last        = (k == KIND_ERROR) || (k == KIND_BOUNDARY);
      return r;
   endfunction

   // next state and records
   always_comb begin
      phase_in  = phase_ff;
      bif_in    = bif_ff;
      nidx_in   = nidx_ff;
      word_in   = word_ff;
      slen_in   = slen_ff;
      ccount_in = ccount_ff;
      off_in    = nxt;
      nterm_in  = nterm_ff;
      saved_in  = saved_ff;
      n         = 0;
      r0        = '0;
      r1        = '0;
      start     = '0;
      name_start = '0;
      case (phase_ff)
         PH_SKIP: begin
            off_in = off_ff;
            if (fin) phase_in = PH_IDLE;
         end
         PH_IDLE: begin
            if (b != OP_MOVEVARS) begin
               off_in = '0;
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, '0, ERR_OPCODE);
            end else begin
               phase_in = PH_NUM; nidx_in = '0; bif_in = '0; word_in = '0;
               slen_in = '0; ccount_in = '0; nterm_in = 1'b0; saved_in = '0;
               off_in = OFFSET_BITS'(1);
               if (fin) begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, OFFSET_BITS'(1), ERR_TRUNC_NUM);
               end
            end
         end
         PH_NUM: begin
            start = cur - OFFSET_BITS'(bif_ff[1:0]);
            if (bif_ff[1:0] != 2'd3) begin
               case (bif_ff[1:0])
                  2'd0:    word_in = {24'd0, b};
                  2'd1:    word_in = {16'd0, b, word_ff[7:0]};
                  default: word_in = {8'd0, b, word_ff[15:0]};
               endcase
               bif_in = {3'd0, bif_ff[1:0]} + 5'd1;
               if (fin) begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, start, ERR_TRUNC_NUM);
               end
            end else begin
               bif_in = '0; word_in = '0;
               if (w[30:23] == 8'hff) begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, start, ERR_NONFINITE);
               end else if (w[30:0] > mag_limit) begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, start, ERR_MAGNITUDE);
               end else begin
                  n = 1; r0 = mk(KIND_NUMERIC, nidx_ff, w, '0, start, '0);
                  if (nidx_ff == LAST_FIRST_BLOCK) begin
                     phase_in = PH_FOOT;
                     if (fin) begin
                        n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_TRUNC_FOOT);
                     end
                  end else if (nidx_ff >= LAST_NUMERIC) begin
                     phase_in = PH_SKY; slen_in = '0;
                     if (fin) begin
                        n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_SKY_UNTERM);
                     end
                  end else begin
                     nidx_in = nidx_ff + 5'd1;
                     if (fin) begin
                        n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_TRUNC_NUM);
                     end
                  end
               end
            end
         end
         PH_FOOT: begin
            if (b > 8'd1) begin
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_BAD_FOOT);
            end else begin
               n = 1; r0 = mk(KIND_FOOT, '0, {24'd0, b}, '0, cur, '0);
               phase_in = PH_NUM; nidx_in = 5'd16; bif_in = '0; word_in = '0;
               if (fin) begin
                  n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_TRUNC_NUM);
               end
            end
         end
         PH_SKY: begin
            if (b == 8'd0) begin
               n = 1; r0 = mk(KIND_SKY_END, '0, {24'd0, slen_ff}, '0, cur, '0);
               phase_in = PH_CTRL;
               if (fin) begin
                  n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_NO_BOUND);
               end
            end else if (slen_ff >= sky_lim) begin
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_SKY_LONG);
            end else begin
               n = 1; r0 = mk(KIND_SKY_CHAR, '0, {24'd0, b}, '0, cur, '0);
               slen_in = slen_ff + 8'd1;
               if (fin) begin
                  n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_SKY_UNTERM);
               end
            end
         end
         PH_CTRL: begin
            if (b == OP_BOUNDARY) begin
               n = 1;
               if (fin) r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_BAD_BOUND);
               else begin
                  r0 = mk(KIND_BOUNDARY, '0, {24'd0, ccount_ff} + 32'd2, '0, cur, '0);
                  phase_in = PH_SKIP;
               end
            end else if (b == OP_MOVEVARS) begin
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_DUP_44);
            end else if (ccount_ff >= ctl_lim) begin
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_CTRL_LIMIT);
            end else begin
               bif_in = '0; slen_in = '0; nterm_in = 1'b0;
               if (b == OP_C32 || b == OP_C5 || b == OP_C39) begin
                  phase_in = (b == OP_C32) ? PH_C32 : (b == OP_C5) ? PH_C5 : PH_C39;
                  if (fin) begin
                     n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_TRUNC_CTRL);
                  end
               end else if (b == OP_C9) begin
                  phase_in = PH_C9;
                  if (fin) begin
                     n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_OP9_UNTERM);
                  end
               end else begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_UNSUPPORTED);
               end
            end
         end
         PH_C32, PH_C5: begin
            start = cur - OFFSET_BITS'(1) - OFFSET_BITS'(bif_ff[0]);
            if (!bif_ff[0]) begin
               saved_in = b; bif_in = 5'd1;
               if (fin) begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, start, ERR_TRUNC_CTRL);
               end
            end else begin
               n = 1;
               if (phase_ff == PH_C32) r0 = mk(KIND_OP32, '0, {24'd0, saved_ff}, b, start, '0);
               else r0 = mk(KIND_OP5, '0, {16'd0, b, saved_ff}, '0, start, '0);
               ccount_in = ccount_ff + 8'd1; phase_in = PH_CTRL; bif_in = '0;
               if (fin) begin
                  n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_NO_BOUND);
               end
            end
         end
         PH_C39: begin
            start = cur - OFFSET_BITS'(1) - OFFSET_BITS'(pos);
            name_start = start + OFFSET_BITS'(3);
            if (fin && pos < OP39_LAST_POS) begin
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, start, ERR_TRUNC_CTRL);
            end else begin
               if (pos == 5'd0) saved_in = b;
               else if (pos == 5'd1) begin
                  n = 1; r0 = mk(KIND_OP39_HD, '0, {24'd0, saved_ff}, b, start, '0);
               end else if (nterm_ff) begin
                  if (b != 8'd0) begin
                     n = 1;
                     r0 = mk(KIND_ERROR, '0, '0, '0, name_start + OFFSET_BITS'(slen_ff),
                             ERR_BAD_NAME);
                  end
               end else if (b == 8'd0) begin
                  if (pos == 5'd2) begin
                     n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, name_start, ERR_BAD_NAME);
                  end else nterm_in = 1'b1;
               end else if (b < PRINT_LO || b > PRINT_HI || pos == OP39_LAST_POS) begin
                  n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, name_start, ERR_BAD_NAME);
               end else begin
                  n = 1; r0 = mk(KIND_OP39_CH, '0, {24'd0, b}, '0, cur, '0);
                  slen_in = slen_ff + 8'd1;
               end
               // an error record above ends the message
               if (!(n == 1 && r0.record_kind == KIND_ERROR)) begin
                  if (pos == OP39_LAST_POS) begin
                     ccount_in = ccount_ff + 8'd1; phase_in = PH_CTRL; bif_in = '0;
                     if (fin) begin
                        if (n == 0) r0 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_NO_BOUND);
                        else r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_NO_BOUND);
                        n = n + 1;
                     end
                  end else bif_in = pos + 5'd1;
               end
            end
         end
         PH_C9: begin
            if (b == 8'd0) begin
               n = 1; r0 = mk(KIND_OP9_END, '0, {24'd0, slen_ff}, '0, cur, '0);
               ccount_in = ccount_ff + 8'd1; phase_in = PH_CTRL;
               if (fin) begin
                  n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_NO_BOUND);
               end
            end else if (slen_ff >= str_lim) begin
               n = 1; r0 = mk(KIND_ERROR, '0, '0, '0, cur, ERR_OP9_LONG);
            end else begin
               n = 1; r0 = mk(KIND_OP9_CHAR, '0, {24'd0, b}, '0, cur, '0);
               slen_in = slen_ff + 8'd1;
               if (fin) begin
                  n = 2; r1 = mk(KIND_ERROR, '0, '0, '0, nxt, ERR_OP9_UNTERM);
               end
            end
         end
         default: begin
            off_in = off_ff;
            phase_in = fin ? PH_IDLE : PH_SKIP;
         end
      endcase
      // any error record closes the message
      if ((n >= 1 && r0.record_kind == KIND_ERROR) || (n == 2 && r1.record_kind == KIND_ERROR))
         phase_in = fin ? PH_IDLE : PH_SKIP;
   end

   assign push           = accept && (n != 0);
   assign push_pair.two  = (n == 2);
   assign push_pair.rec0 = r0;
   assign push_pair.rec1 = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bif_ff    <= '0;
         nidx_ff   <= '0;
         word_ff   <= '0;
         slen_ff   <= '0;
         ccount_ff <= '0;
         off_ff    <= '0;
         nterm_ff  <= 1'b0;
         saved_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         nidx_ff   <= nidx_in;
         word_ff   <= word_in;
         slen_ff   <= slen_in;
         ccount_ff <= ccount_in;
         off_ff    <= off_in;
         nterm_ff  <= nterm_in;
         saved_ff  <= saved_in;
      end
   end
endmodule
`default_nettype wire

@@ src/mvp_queue.sv @@
// short record-pair queue between front and back
`default_nettype none
module mvp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mvp_pkg::rec_pair_type push_pair,
   input  wire logic                  pop,
   output mvp_pkg::rec_pair_type      head,
   output mvp_pkg::q_status_type      status
);
   import mvp_pkg::*;

   rec_pair_type slot_ff [2];
   rec_pair_type slot0_in, slot1_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign head         = slot_ff[0];
   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);

   always_comb begin
      slot0_in = slot_ff[0];
      slot1_in = slot_ff[1];
      cnt_in   = cnt_ff;
      if (pop) begin
         slot0_in = slot_ff[1];
         cnt_in   = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) slot0_in = push_pair;
         else slot1_in = push_pair;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot0_in;
      slot_ff[1] <= slot1_in;
   end
endmodule
`default_nettype wire

@@ src/mvp_back.sv @@
// back end: issues queued record pairs one record per transaction
`default_nettype none
module mvp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mvp_pkg::rec_pair_type head,
   input  wire mvp_pkg::q_status_type q_status,
   output logic                       pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output mvp_pkg::rsp_payload_type   out_item
);
   import mvp_pkg::*;

   logic second_ff, second_in;

   assign out_valid = !q_status.empty;
   assign out_item  = second_ff ? head.rec1 : head.rec0;
   assign pop       = out_valid && out_ready && (second_ff || !head.two);

   always_comb begin
      second_in = second_ff;
      if (out_valid && out_ready) second_in = !second_ff && head.two;
   end

   always_ff @(posedge clock) begin
      if (reset) second_ff <= 1'b0;
      else second_ff <= second_in;
   end
endmodule
`default_nettype wire

@@ src/movevars_message_stream_parser.sv @@
// top level of the movevars message stream parser
// a record is written into the queue when its byte is accepted and is offered from the queue head
// throughput: one byte per cycle while the queue is not full; bytes giving two records take two output transactions
// the two-entry queue lets the parser run ahead while the output is stalled
// reset: synchronous active high, parser back to waiting for an opcode byte,
// queue emptied, configuration registers at their documented defaults
`default_nettype none
module movevars_message_stream_parser #(
   parameter int MAX_STRING_LEN = 255,
   parameter int MAX_CONTROLS   = 255,
   parameter int OFFSET_BITS    = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire mvp_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output mvp_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [3:0]               csr_paddr,
   input  wire logic [31:0]              csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import mvp_pkg::*;

   // configuration registers
   logic [7:0]  sky_ff, str_ff, ctl_ff;
   logic [30:0] mag_ff;
   logic        wr;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sky_ff <= 8'd255;
         str_ff <= 8'd255;
         ctl_ff <= 8'd64;
         mag_ff <= 31'h49742400;
      end else if (wr) begin
         case (reg_idx)
            REG_SKY_LIMIT:  sky_ff <= csr_pwdata[7:0];
            REG_STR_LIMIT:  str_ff <= csr_pwdata[7:0];
            REG_CTRL_LIMIT: ctl_ff <= csr_pwdata[7:0];
            REG_MAG_LIMIT:  mag_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (reg_idx)
         REG_SKY_LIMIT:  csr_prdata = {24'd0, sky_ff};
         REG_STR_LIMIT:  csr_prdata = {24'd0, str_ff};
         REG_CTRL_LIMIT: csr_prdata = {24'd0, ctl_ff};
         REG_MAG_LIMIT:  csr_prdata = {1'b0, mag_ff};
         default:        csr_prdata = '0;
      endcase
   end

   logic         push, pop;
   rec_pair_type push_pair, head;
   q_status_type q_status;

   // front: parses one byte per transaction
   mvp_front #(
      .MAX_STRING_LEN (MAX_STRING_LEN),
      .MAX_CONTROLS   (MAX_CONTROLS),
      .OFFSET_BITS    (OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_item    (req_payload),
      .sky_limit  (sky_ff),
      .str_limit  (str_ff),
      .ctrl_limit (ctl_ff),
      .mag_limit  (mag_ff),
      .push       (push),
      .push_pair  (push_pair),
      .q_status   (q_status)
   );

   // queue of record pairs
   mvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pair (push_pair),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // back: serialises pairs onto the result channel
   mvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   // no push into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("push into full queue");
   // error and boundary records always carry last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.record_kind == KIND_ERROR ||
                    rsp_payload.record_kind == KIND_BOUNDARY) |-> rsp_payload.last)
      else $error("closing record without last");
   // an unpopped head stays in place
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire
